/* src/integer_calculator_alu_assert.svh */
// Assertion macros for the integer calculator ALU checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef INTEGER_CALCULATOR_ALU_ASSERT_SVH
`define INTEGER_CALCULATOR_ALU_ASSERT_SVH

// same-cycle implication
`define ICA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define ICA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* src/ica_pkg.sv */
// Package for the integer calculator ALU: request/response types,
// operation and status codes, sequencer states. No dependencies.
`default_nettype none

package ica_pkg;

	localparam int MUL_W = 32;

	localparam logic [3:0] FN_STOP  = 4'd0;
	localparam logic [3:0] FN_ADD   = 4'd1;
	localparam logic [3:0] FN_SUB   = 4'd2;
	localparam logic [3:0] FN_SUBB  = 4'd3;
	localparam logic [3:0] FN_MUL   = 4'd4;
	localparam logic [3:0] FN_RDIV  = 4'd5;
	localparam logic [3:0] FN_RDIVB = 4'd6;
	localparam logic [3:0] FN_QUO   = 4'd7;
	localparam logic [3:0] FN_QUOB  = 4'd8;
	localparam logic [3:0] FN_REM   = 4'd9;
	localparam logic [3:0] FN_REMB  = 4'd10;
	localparam logic [3:0] FN_POW   = 4'd11;
	localparam logic [3:0] FN_POWB  = 4'd12;

	localparam logic [2:0] STS_INT     = 3'd0;
	localparam logic [2:0] STS_SCALED  = 3'd1;
	localparam logic [2:0] STS_DIVZERO = 3'd2;
	localparam logic [2:0] STS_INVALID = 3'd3;
	localparam logic [2:0] STS_OVF     = 3'd4;
	localparam logic [2:0] STS_STOP    = 3'd5;

	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [63:0] result;
		logic [2:0]         status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_MULFIN,
		S_DIV,
		S_PLO,
		S_PHI,
		S_PCHK
	} state_t;

	typedef enum logic [1:0] {
		K_FIN,
		K_MUL,
		K_DIV,
		K_POW
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] res;
		logic [2:0]  sts;
	} dec_t;

endpackage

`default_nettype wire

/* src/integer_calculator_alu.sv */
// Integer calculator ALU top level: sequencer and datapath.
// Depends on ica_pkg, ica_div and ica_mul.
//
// Usage:
//   A request (req: func, operand_a, operand_b) is taken on a rising edge
//   with start high and busy low. busy stays high until the result is out.
//   The result (rsp: result, status) shows for exactly one cycle with done
//   high; the receiver cannot hold it off, so capture it then.
// Path from accept to done:
//   stop, add, subtract, invalid, zero divisor, trivial powers: dispatch only
//   multiply: one pass through the shared multiplier
//   divide, quotient, remainder: the one-bit-per-cycle divider runs over an
//     OPERAND_WIDTH + 6 bit dividend
//   power: each exponent step is two multiplier passes plus the overflow
//     check, and at most 64 steps run before saturation
// A new request may be taken in the cycle done is high.
// Reset clears the sequencer and done; no result depends on state left by an earlier request.
`default_nettype none

module integer_calculator_alu #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ica_pkg::req_t req,
	output logic          done,
	output ica_pkg::rsp_t rsp
);
	import ica_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int NW = W + 6;

	state_t state_q, state_d;

	logic [3:0]          func_q;
	logic signed [W-1:0] a_q, b_q;
	logic [W-1:0]        abs_q;
	logic [W-1:0]        cnt_q;
	logic                neg_q;
	logic [63:0]         mag_q;
	logic [63:0]         plo_q;
	rsp_t                rsp_q;
	logic                done_q;

	logic                swap;
	logic signed [W-1:0] p, q;
	logic                p_neg, q_neg;
	logic [W-1:0]        p_mag, q_mag;
	logic signed [63:0]  p64, q64;
	logic                is_real, is_quo, is_rem, is_pow;
	logic [NW-1:0]       num_ext, num_real, div_num;
	dec_t                dec;

	logic                div_start, div_done;
	logic [NW-1:0]       div_quo;
	logic [W-1:0]        div_rem;
	logic                rnd;
	logic [63:0]         quo_r;

	logic [MUL_W-1:0]    mul_x, mul_y;
	logic [2*MUL_W-1:0]  mul_p;
	logic [95:0]         prod, limit;
	logic                pow_ovf;

	logic                fin;
	logic [63:0]         fin_res;
	logic [2:0]          fin_sts;

	assign swap = (func_q == FN_SUBB) || (func_q == FN_RDIVB) || (func_q == FN_QUOB)
		|| (func_q == FN_REMB) || (func_q == FN_POWB);
	assign p     = swap ? b_q : a_q;
	assign q     = swap ? a_q : b_q;
	assign p_neg = p[W-1];
	assign q_neg = q[W-1];
	assign p_mag = p_neg ? (~p + 1'b1) : p;
	assign q_mag = q_neg ? (~q + 1'b1) : q;
	assign p64   = 64'(p);
	assign q64   = 64'(q);

	assign is_real = (func_q == FN_RDIV) || (func_q == FN_RDIVB);
	assign is_quo  = (func_q == FN_QUO) || (func_q == FN_QUOB);
	assign is_rem  = (func_q == FN_REM) || (func_q == FN_REMB);
	assign is_pow  = (func_q == FN_POW) || (func_q == FN_POWB);

	// times 100 as shifts
	assign num_ext  = NW'(p_mag);
	assign num_real = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
	assign div_num  = is_real ? num_real : num_ext;

	always_comb begin
		dec.kind = K_FIN;
		dec.res  = '0;
		dec.sts  = STS_INT;
		priority if (func_q == FN_STOP) begin
			dec.sts = STS_STOP;
		end else if (func_q == FN_ADD) begin
			dec.res = p64 + q64;
		end else if ((func_q == FN_SUB) || (func_q == FN_SUBB)) begin
			dec.res = p64 - q64;
		end else if (func_q == FN_MUL) begin
			dec.kind = K_MUL;
		end else if (is_real || is_quo || is_rem) begin
			if (q == '0) begin
				dec.sts = STS_DIVZERO;
			end else begin
				dec.kind = K_DIV;
			end
		end else if (is_pow) begin
			if (q == '0) begin
				dec.res = 64'd1;
			end else if (p == W'(1)) begin
				dec.res = 64'd1;
			end else if (p == '1) begin
				dec.res = q[0] ? '1 : 64'd1;
			end else if (p == '0) begin
				dec.sts = q_neg ? STS_DIVZERO : STS_INT;
			end else if (q_neg) begin
				dec.res = '0;
			end else begin
				dec.kind = K_POW;
			end
		end else begin
			dec.sts = STS_INVALID;
		end
	end

	ica_div #(.NW(NW), .DW(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (q_mag),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign rnd   = ((W + 1)'(div_rem) << 1) >= (W + 1)'(q_mag);
	assign quo_r = 64'(div_quo) + 64'(rnd);

	ica_mul u_mul (
		.clk (clk),
		.x   (mul_x),
		.y   (mul_y),
		.p   (mul_p)
	);

	assign prod    = {mul_p, 32'd0} + 96'(plo_q);
	assign limit   = neg_q ? 96'(INT64_MIN) : 96'(INT64_MAX);
	assign pow_ovf = prod > limit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_d = S_DISP;
			S_DISP: begin
				unique case (dec.kind)
					K_FIN: state_d = S_IDLE;
					K_MUL: state_d = S_MULFIN;
					K_DIV: state_d = S_DIV;
					K_POW: state_d = S_PLO;
				endcase
			end
			S_MULFIN: state_d = S_IDLE;
			S_DIV:    if (div_done) state_d = S_IDLE;
			S_PLO:    state_d = S_PHI;
			S_PHI:    state_d = S_PCHK;
			S_PCHK:   state_d = (pow_ovf || (cnt_q == W'(1))) ? S_IDLE : S_PLO;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy      = state_q != S_IDLE;
		div_start = (state_q == S_DISP) && (dec.kind == K_DIV);
		mul_x     = MUL_W'(p_mag);
		mul_y     = MUL_W'(q_mag);
		fin       = 1'b0;
		fin_res   = '0;
		fin_sts   = STS_INT;
		unique case (state_q)
			S_DISP: begin
				fin     = dec.kind == K_FIN;
				fin_res = dec.res;
				fin_sts = dec.sts;
			end
			S_MULFIN: begin
				fin     = 1'b1;
				fin_res = (p_neg ^ q_neg) ? (64'd0 - mul_p) : mul_p;
			end
			S_DIV: begin
				fin = div_done;
				priority if (is_real) begin
					fin_res = (p_neg ^ q_neg) ? (64'd0 - quo_r) : quo_r;
					fin_sts = STS_SCALED;
				end else if (is_quo) begin
					fin_res = (p_neg ^ q_neg) ? (64'd0 - 64'(div_quo)) : 64'(div_quo);
				end else begin
					fin_res = p_neg ? (64'd0 - 64'(div_rem)) : 64'(div_rem);
				end
			end
			S_PLO: begin
				mul_x = mag_q[31:0];
				mul_y = MUL_W'(abs_q);
			end
			S_PHI: begin
				mul_x = mag_q[63:32];
				mul_y = MUL_W'(abs_q);
			end
			S_PCHK: begin
				fin = pow_ovf || (cnt_q == W'(1));
				if (pow_ovf) begin
					fin_res = neg_q ? INT64_MIN : INT64_MAX;
					fin_sts = STS_OVF;
				end else begin
					fin_res = neg_q ? (64'd0 - prod[63:0]) : prod[63:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			func_q <= req.func;
			a_q    <= req.operand_a[W-1:0];
			b_q    <= req.operand_b[W-1:0];
		end
		if ((state_q == S_DISP) && (dec.kind == K_POW)) begin
			mag_q <= 64'd1;
			abs_q <= p_mag;
			cnt_q <= q;
			neg_q <= p_neg & q[0];
		end
		if (state_q == S_PHI) begin
			plo_q <= mul_p;
		end
		if ((state_q == S_PCHK) && !fin) begin
			mag_q <= prod[63:0];
			cnt_q <= cnt_q - 1'b1;
		end
		if (fin) begin
			rsp_q.result <= fin_res;
			rsp_q.status <= fin_sts;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

/* src/ica_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses nothing outside this file.
`default_nettype none

module ica_div #(
	parameter int NW = 38,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* src/ica_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
// Depends on ica_pkg for the multiplier width.
`default_nettype none

module ica_mul (
	input  logic                       clk,
	input  logic [ica_pkg::MUL_W-1:0]  x,
	input  logic [ica_pkg::MUL_W-1:0]  y,
	output logic [2*ica_pkg::MUL_W-1:0] p
);
	import ica_pkg::*;

	logic [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (2*MUL_W)'(x) * (2*MUL_W)'(y);
	end

	assign p = p_q;

endmodule

`default_nettype wire

/* src/ica_checker.sv */
// Port-level checker for the integer calculator ALU, bound to the top.
// Depends on ica_pkg and integer_calculator_alu_assert.svh.
`default_nettype none

`include "integer_calculator_alu_assert.svh"

module ica_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire ica_pkg::rsp_t rsp
);
	import ica_pkg::*;

	logic err_sts;

	assign err_sts = (rsp.status == STS_DIVZERO) || (rsp.status == STS_INVALID)
		|| (rsp.status == STS_STOP);

	`ICA_ASSERT_NXT(a_busy_after_req, start && !busy, busy, "busy low after request")
	`ICA_ASSERT_NXT(a_done_single, done, !done, "done held two cycles")
	`ICA_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")
	`ICA_ASSERT_IMP(a_err_zero, done && err_sts, rsp.result == 64'd0, "error with result")

endmodule

bind integer_calculator_alu ica_checker u_ica_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire

/* tb/tb_integer_calculator_alu.sv */
// Testbench for integer_calculator_alu: directed and random requests, each result
// checked against a behavioral model of the calculator. Depends on ica_pkg.
`timescale 1ns / 1ps

module tb_integer_calculator_alu;
	import ica_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	req_t req = '0;
	rsp_t rsp;

	integer_calculator_alu #(.OPERAND_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #4 clk = ~clk;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int mismatches = 0;
	int gap_left = 0;
	int burst_left = 0;
	bit hold_for_drain = 1'b0;
	longint cycles = 0;

	function automatic logic [63:0] mag64(logic signed [63:0] x);
		return x[63] ? -x : x;
	endfunction

	function automatic logic signed [63:0] scaled_quotient(logic signed [63:0] num,
			logic signed [63:0] den);
		logic [63:0] n, d, q, r;
		n = mag64(num) * 64'd100;
		d = mag64(den);
		q = n / d;
		r = n % d;
		if (2 * r >= d) q++;
		return (num[63] != den[63]) ? -q : q;
	endfunction

	function automatic logic signed [63:0] power_of(logic signed [63:0] base,
			logic signed [63:0] ex, output logic [2:0] sts);
		logic neg;
		logic [63:0] ab, acc, lim;
		sts = STS_INT;
		if (ex == 0 || base == 1) return 64'sd1;
		if (base == -1) return ex[0] ? -64'sd1 : 64'sd1;
		if (base == 0) begin
			if (ex < 0) sts = STS_DIVZERO;
			return 0;
		end
		if (ex < 0) return 0;
		neg = base[63] & ex[0];
		ab = mag64(base);
		lim = neg ? INT64_MIN : INT64_MAX;
		acc = 1;
		for (longint i = 0; i < ex; i++) begin
			if (acc > lim / ab) begin
				sts = STS_OVF;
				return neg ? INT64_MIN : INT64_MAX;
			end
			acc = acc * ab;
		end
		return neg ? -acc : acc;
	endfunction

	function automatic rsp_t calc_result(req_t r);
		rsp_t o;
		logic signed [63:0] a, b;
		a = r.operand_a;
		b = r.operand_b;
		o.result = 0;
		o.status = STS_INT;
		case (r.func)
			FN_STOP: o.status = STS_STOP;
			FN_ADD: o.result = a + b;
			FN_SUB: o.result = a - b;
			FN_SUBB: o.result = b - a;
			FN_MUL: o.result = a * b;
			FN_RDIV: if (b == 0) o.status = STS_DIVZERO;
				else begin o.result = scaled_quotient(a, b); o.status = STS_SCALED; end
			FN_RDIVB: if (a == 0) o.status = STS_DIVZERO;
				else begin o.result = scaled_quotient(b, a); o.status = STS_SCALED; end
			FN_QUO: if (b == 0) o.status = STS_DIVZERO; else o.result = a / b;
			FN_QUOB: if (a == 0) o.status = STS_DIVZERO; else o.result = b / a;
			FN_REM: if (b == 0) o.status = STS_DIVZERO; else o.result = a % b;
			FN_REMB: if (a == 0) o.status = STS_DIVZERO; else o.result = b % a;
			FN_POW: o.result = power_of(a, b, o.status);
			FN_POWB: o.result = power_of(b, a, o.status);
			default: o.status = STS_INVALID;
		endcase
		return o;
	endfunction

	// driver: bursts with gaps; holds off while a drain is requested
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				// start still high from an earlier request; none was taken at the last rising edge
			end
			if (busy) begin
			end else if (hold_for_drain || pending_reqs.size() == 0) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else begin
				req <= pending_reqs[0];
				start <= 1'b1;
			end
		end
	end

	// accept point: pop the request and record its expected result
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_rsps.push_back(calc_result(req));
			void'(pending_reqs.pop_front());
			if (burst_left > 0) burst_left--;
			else begin
				burst_left = $urandom_range(0, 12);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles++;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d status %0d",
					rsp.result, rsp.status);
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (e.result !== rsp.result || e.status !== rsp.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d got %0d/%0d",
							e.result, e.status, rsp.result, rsp.status);
				end
			end
		end
		if (cycles > 2000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 8) - 4;
			1: return $urandom_range(0, 200) - 100;
			2: return {{31{1'b0}}, 1'b1} << $urandom_range(0, 31);
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(logic [3:0] f, logic [31:0] a, logic [31:0] b);
		req_t r;
		r.func = f;
		r.operand_a = a;
		r.operand_b = b;
		pending_reqs.push_back(r);
	endtask

	initial begin
		logic [3:0] f;
		logic [31:0] a, b;
		repeat (10) @(posedge clk);
		arst_n = 1'b1;
		for (int k = 0; k <= 15; k++) add_req(4'(k), 32'h7FFF_FFFF, 32'h8000_0000);
		add_req(FN_RDIV, 7, 0);
		add_req(FN_REM, 7, 0);
		add_req(FN_REMB, 0, 7);
		add_req(FN_POW, 0, -3);
		add_req(FN_POW, -1, -3);
		add_req(FN_POW, 5, -2);
		add_req(FN_POW, 0, 0);
		add_req(FN_POW, -2, 63);
		add_req(FN_RDIV, -1, 8);
		wait (pending_reqs.size() == 0);
		hold_for_drain = 1'b1;
		wait (expected_rsps.size() == 0);
		hold_for_drain = 1'b0;
		for (int n = 0; n < 1000; n++) begin
			f = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 15)
				: $urandom_range(0, 12));
			a = rand_operand();
			b = rand_operand();
			if ((f == FN_POW) && $urandom_range(0, 1)) b = $urandom_range(0, 70) - 5;
			if ((f == FN_POWB) && $urandom_range(0, 1)) a = $urandom_range(0, 70) - 5;
			add_req(f, a, b);
		end
		wait (pending_reqs.size() == 0);
		wait (expected_rsps.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
